// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent sequence starting at the same edge
`define CHK_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

`endif

// ----- rtl/core/chwt_pkg.sv -----
// ----------------------------------------------------------------------------
// chwt_pkg
// Shared constants, angle table and stage types for the compass heading block.
// ----------------------------------------------------------------------------
package chwt_pkg;

  // heading resolution and cordic depth
  localparam int FRAC_BITS       = 4;
  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int NUM_STAGES      = (CORDIC_STAGES < ANGLE_TABLE_LEN) ?
                                   CORDIC_STAGES : ANGLE_TABLE_LEN;

  // angles in heading units
  localparam int FULL_UNITS     = 360 << FRAC_BITS;
  localparam int HALF_UNITS     = 180 << FRAC_BITS;
  localparam int DEFAULT_WINDOW = 10 << FRAC_BITS;

  // field and datapath widths
  localparam int MAG_W       = 16;
  localparam int XY_W        = MAG_W + 3;
  localparam int Z_W         = 32;
  localparam int HEADING_W   = $clog2(FULL_UNITS + 1);
  localparam int TARGET_W    = 13;
  localparam int WINDOW_W    = 12;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int CMP_W       = ((HEADING_W > TARGET_W) ? HEADING_W : TARGET_W) + 2;
  localparam int PROD_W      = Z_W + HEADING_W;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW = 2'd1;

  // half turn as a binary angle
  localparam logic [Z_W-1:0] Z_HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [Z_W-1:0] ATAN_TURNS [ANGLE_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // one cordic pipeline stage
  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
  } cordic_t;

  // configuration as seen by the evaluation pipeline
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [WINDOW_W-1:0] window;
  } cfg_t;

  // one finished result
  typedef struct packed {
    logic                 valid;
    logic [HEADING_W-1:0] heading;
    logic                 on_target;
    logic                 turn_dir;
  } result_t;

endpackage

// ----- rtl/core/chwt_eval.sv -----
// ----------------------------------------------------------------------------
// chwt_eval
// Scales the binary angle to heading units, then runs the window and turn
// tests against the target, in three register stages.
// ----------------------------------------------------------------------------
module chwt_eval (
  input  logic              clk,
  input  logic              rst_n,
  input  chwt_pkg::cordic_t angle_in,
  input  chwt_pkg::cfg_t    cfg,
  output chwt_pkg::result_t res
);

  localparam logic [chwt_pkg::HEADING_W-1:0] FULL_H =
    chwt_pkg::HEADING_W'(chwt_pkg::FULL_UNITS);
  localparam logic signed [chwt_pkg::CMP_W-1:0] FULL_S =
    chwt_pkg::CMP_W'(chwt_pkg::FULL_UNITS);
  localparam logic signed [chwt_pkg::CMP_W-1:0] HALF_S =
    chwt_pkg::CMP_W'(chwt_pkg::HALF_UNITS);
  localparam logic [chwt_pkg::PROD_W-1:0] ROUND_HALF =
    chwt_pkg::PROD_W'(1) << (chwt_pkg::Z_W - 1);

  // multiply stage
  logic                          m_valid_r;
  logic                          m_zero_r;
  logic [chwt_pkg::PROD_W-1:0]   prod_r;
  logic [chwt_pkg::PROD_W-1:0]   prod_nxt;

  // round stage
  logic                          r_valid_r;
  logic [chwt_pkg::HEADING_W-1:0] h_r;
  logic [chwt_pkg::HEADING_W-1:0] h_nxt;
  logic [chwt_pkg::HEADING_W-1:0] d_r;
  logic [chwt_pkg::HEADING_W-1:0] d_nxt;
  logic [chwt_pkg::PROD_W-1:0]    hsum;
  logic [chwt_pkg::HEADING_W-1:0] hraw;
  logic signed [chwt_pkg::CMP_W-1:0] dif;

  // output stage
  chwt_pkg::result_t              res_r;
  logic                           on_nxt;
  logic                           turn_nxt;
  logic signed [chwt_pkg::CMP_W-1:0] d_s;
  logic signed [chwt_pkg::CMP_W-1:0] fold;
  logic signed [chwt_pkg::CMP_W-1:0] h_s;

  // target derived values; user must keep them static while items are in flight
  logic signed [chwt_pkg::CMP_W-1:0] t_raw;
  logic signed [chwt_pkg::CMP_W-1:0] t_c;
  logic signed [chwt_pkg::CMP_W-1:0] t_mod;
  logic signed [chwt_pkg::CMP_W-1:0] p_plus;
  logic signed [chwt_pkg::CMP_W-1:0] p_minus;
  logic signed [chwt_pkg::CMP_W-1:0] w_s;

  // clamp target to a full turn and form the opposite bearings
  always_comb begin
    t_raw   = $signed({{(chwt_pkg::CMP_W - chwt_pkg::TARGET_W){1'b0}}, cfg.target});
    t_c     = (t_raw > FULL_S) ? FULL_S : t_raw;
    t_mod   = (t_c == FULL_S) ? '0 : t_c;
    p_plus  = t_c + HALF_S;
    if (p_plus > FULL_S) begin
      p_plus = p_plus - FULL_S;
    end
    p_minus = t_c - HALF_S;
    if (p_minus < 0) begin
      p_minus = p_minus + FULL_S;
    end
    w_s     = $signed({{(chwt_pkg::CMP_W - chwt_pkg::WINDOW_W){1'b0}}, cfg.window});
  end

  // binary angle times heading units per turn
  assign prod_nxt = {{chwt_pkg::HEADING_W{1'b0}}, angle_in.z} *
                    chwt_pkg::PROD_W'(chwt_pkg::FULL_UNITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= angle_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    m_zero_r <= angle_in.zero;
    prod_r   <= prod_nxt;
  end

  // round half up, wrap a full turn to zero, distance from target
  always_comb begin
    hsum = prod_r + ROUND_HALF;
    hraw = hsum[chwt_pkg::PROD_W-1:chwt_pkg::Z_W];
    if (m_zero_r) begin
      h_nxt = '0;
    end else if (hraw >= FULL_H) begin
      h_nxt = hraw - FULL_H;
    end else begin
      h_nxt = hraw;
    end
    dif = $signed({{(chwt_pkg::CMP_W - chwt_pkg::HEADING_W){1'b0}}, h_nxt}) - t_mod;
    if (dif < 0) begin
      dif = dif + FULL_S;
    end
    d_nxt = dif[chwt_pkg::HEADING_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
    end else begin
      r_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    d_r <= d_nxt;
  end

  // circular window test and three-way turn rule
  always_comb begin
    d_s  = $signed({{(chwt_pkg::CMP_W - chwt_pkg::HEADING_W){1'b0}}, d_r});
    h_s  = $signed({{(chwt_pkg::CMP_W - chwt_pkg::HEADING_W){1'b0}}, h_r});
    fold = ((FULL_S - d_s) < d_s) ? (FULL_S - d_s) : d_s;
    on_nxt = (fold <= w_s);
    priority if (p_plus <= HALF_S) begin
      turn_nxt = !((h_s < p_plus) || (h_s > t_c));
    end else if (p_minus >= HALF_S) begin
      turn_nxt = (h_s > p_minus) || (h_s < t_c);
    end else begin
      turn_nxt = !(h_s > t_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r.heading   <= h_r;
    res_r.on_target <= on_nxt;
    res_r.turn_dir  <= turn_nxt;
  end

  assign res = res_r;

endmodule

// ----- rtl/core/compass_heading_window_turn.sv -----
// ----------------------------------------------------------------------------
// compass_heading_window_turn
// Magnetometer heading by pipelined vectoring cordic, with target window and
// turn direction.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: drive in_mag_x / in_mag_y and raise start; the pair is
//   taken at every edge with start high and busy low. busy stays low, so a
//   new pair can be taken at every clock edge.
//   result channel: out_valid is high for exactly one cycle per input pair,
//   with out_heading (1/16 degree, 0..5759), out_on_target and out_turn_dir.
//   results leave in input order.
//   path: an input pair passes one input register, one register per cordic
//   iteration, then the multiply, round and compare registers, before its
//   result shows. throughput is one pair per cycle, set by the fully
//   unrolled cordic pipeline.
//   configuration: cfg_index 0 is the target heading, 1 the window half
//   width; a transfer completes at any edge with cfg_valid high. write it
//   only while no pair is in flight.
//   reset: rst_n low clears all valid bits and loads target 0 and a window
//   of ten degrees; payload registers keep whatever they hold.
//   the receiver takes every result as it comes and cannot stall the pipe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module compass_heading_window_turn (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [chwt_pkg::MAG_W-1:0]    in_mag_x,
  input  logic signed [chwt_pkg::MAG_W-1:0]    in_mag_y,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [chwt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [chwt_pkg::CFG_DATA_W-1:0]      cfg_data,
  // result channel
  output logic                                 out_valid,
  output logic [chwt_pkg::HEADING_W-1:0]       out_heading,
  output logic                                 out_on_target,
  output logic                                 out_turn_dir
);

  localparam int LATENCY = chwt_pkg::NUM_STAGES + 4;

  logic [chwt_pkg::TARGET_W-1:0] target_r;
  logic [chwt_pkg::WINDOW_W-1:0] window_r;
  chwt_pkg::cfg_t                cfg;

  chwt_pkg::cordic_t pipe_r   [chwt_pkg::NUM_STAGES+1];
  chwt_pkg::cordic_t pipe_nxt [chwt_pkg::NUM_STAGES+1];

  chwt_pkg::result_t res;
  logic              in_xfer;

  // the pipeline never holds off either side
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_xfer   = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      window_r <= chwt_pkg::WINDOW_W'(chwt_pkg::DEFAULT_WINDOW);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == chwt_pkg::CFG_TARGET) begin
        target_r <= cfg_data[chwt_pkg::TARGET_W-1:0];
      end else if (cfg_index == chwt_pkg::CFG_WINDOW) begin
        window_r <= cfg_data[chwt_pkg::WINDOW_W-1:0];
      end
    end
  end

  assign cfg.target = target_r;
  assign cfg.window = window_r;

  // input register: fold the left half plane onto the right
  always_comb begin
    pipe_nxt[0].valid = in_xfer;
    pipe_nxt[0].zero  = (in_mag_x == '0) && (in_mag_y == '0);
    if (in_mag_x < 0) begin
      pipe_nxt[0].x = -chwt_pkg::XY_W'(in_mag_x);
      pipe_nxt[0].y = -chwt_pkg::XY_W'(in_mag_y);
      pipe_nxt[0].z = chwt_pkg::Z_HALF_TURN;
    end else begin
      pipe_nxt[0].x = chwt_pkg::XY_W'(in_mag_x);
      pipe_nxt[0].y = chwt_pkg::XY_W'(in_mag_y);
      pipe_nxt[0].z = '0;
    end
  end

  // one cordic iteration per stage
  for (genvar i = 0; i < chwt_pkg::NUM_STAGES; i++) begin : g_cordic
    logic signed [chwt_pkg::XY_W-1:0] xc;
    logic signed [chwt_pkg::XY_W-1:0] yc;
    logic signed [chwt_pkg::XY_W-1:0] xs;
    logic signed [chwt_pkg::XY_W-1:0] ys;

    always_comb begin
      xc = pipe_r[i].x;
      yc = pipe_r[i].y;
      xs = xc >>> i;
      ys = yc >>> i;
      pipe_nxt[i+1].valid = pipe_r[i].valid;
      pipe_nxt[i+1].zero  = pipe_r[i].zero;
      if (!yc[chwt_pkg::XY_W-1]) begin
        pipe_nxt[i+1].x = xc + ys;
        pipe_nxt[i+1].y = yc - xs;
        pipe_nxt[i+1].z = pipe_r[i].z + chwt_pkg::ATAN_TURNS[i];
      end else begin
        pipe_nxt[i+1].x = xc - ys;
        pipe_nxt[i+1].y = yc + xs;
        pipe_nxt[i+1].z = pipe_r[i].z - chwt_pkg::ATAN_TURNS[i];
      end
    end
  end

  // pipeline registers: valid bits reset, payload free running
  for (genvar s = 0; s <= chwt_pkg::NUM_STAGES; s++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[s].valid <= 1'b0;
      end else begin
        pipe_r[s].valid <= pipe_nxt[s].valid;
      end
    end

    always_ff @(posedge clk) begin
      pipe_r[s].zero <= pipe_nxt[s].zero;
      pipe_r[s].x    <= pipe_nxt[s].x;
      pipe_r[s].y    <= pipe_nxt[s].y;
      pipe_r[s].z    <= pipe_nxt[s].z;
    end
  end

  // scaling, window and turn evaluation
  chwt_eval u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .angle_in (pipe_r[chwt_pkg::NUM_STAGES]),
    .cfg      (cfg),
    .res      (res)
  );

  assign out_valid     = res.valid;
  assign out_heading   = res.heading;
  assign out_on_target = res.on_target;
  assign out_turn_dir  = res.turn_dir;

  // checks
  `CHK_ALWAYS(a_heading_range, !out_valid || (out_heading < chwt_pkg::HEADING_W'(chwt_pkg::FULL_UNITS)), "heading out of range")
  `CHK_IMPLIES(a_latency, in_xfer, ##LATENCY out_valid, "result missing after pipeline latency")
  `CHK_IMPLIES(a_zero_vec, in_xfer && (in_mag_x == '0) && (in_mag_y == '0), ##LATENCY (out_heading == '0), "zero vector heading not zero")

endmodule
